// ===== rtl/core/msp_pkg.sv =====
// Shared types, register map and reset values of the servo pulse generator.
`default_nettype none

package msp_pkg;

  // default sizes
  localparam int NUM_CHANNELS_DEF = 8;
  localparam int IDLE_WIDTH_DEF   = 24;

  // field widths
  localparam int COUNT_W    = 12;
  localparam int PRESCALE_W = 8;
  localparam int TIMEOUT_W  = 24;
  localparam int STATUS_W   = 2;

  // APB register map, register index = paddr[3:2]
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_SLOT_TICKS = 2'd0;
  localparam logic [1:0] REG_PRESCALE   = 2'd1;
  localparam logic [1:0] REG_IDLE_TICKS = 2'd2;

  // register reset values
  localparam logic [COUNT_W-1:0]    SLOT_TICKS_RST = 12'd250;
  localparam logic [PRESCALE_W-1:0] PRESCALE_RST   = 8'd6;
  localparam logic [TIMEOUT_W-1:0]  IDLE_TICKS_RST = 24'd0;

  // word kinds
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_CHANNEL  = 2'd1,
    ST_BAD_POSITION = 2'd2
  } status_t;

  typedef struct packed {
    logic [COUNT_W-1:0]    slot_ticks;
    logic [PRESCALE_W-1:0] prescale;
    logic [TIMEOUT_W-1:0]  idle_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/msp_if.sv =====
// Valid/ready word channels of the servo pulse generator: commands in, results out.
`default_nettype none

interface msp_req_if #(
  parameter int CH_W = 3
);
  import msp_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [CH_W-1:0]    channel;
  logic [COUNT_W-1:0] position;

  modport source (output valid, mode, channel, position, input ready);
  modport sink   (input valid, mode, channel, position, output ready);
endinterface

interface msp_rsp_if #(
  parameter int NUM_CHANNELS = 8
);
  import msp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [NUM_CHANNELS-1:0] pins;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_W-1:0]      channel_position;

  modport source (output valid, pins, status, channel_position, input ready);
  modport sink   (input valid, pins, status, channel_position, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/multichannel_servo_pulse_generator.sv =====
// Top level of the time-multiplexed servo pulse generator.
//
// Usage:
//   req carries words: mode 0 is one base clock, mode 1 sets channel's
//   position (high time in pulse ticks). rsp returns one word for every
//   request word: the pin levels after it, a status (ok, bad channel,
//   bad position) and the stored position of the named channel.
//   The APB port holds slot_ticks (0x0), prescale (0x4) and idle_ticks
//   (0x8); pready is tied high, write only while no word is in flight.
// Pipeline:
//   input register -> pulse engine logic -> result register. A word taken
//   into the input register enters the result register when that one is
//   free or being taken, and is on rsp from then; one word per cycle
//   while rsp is not held. The position store is two small RAMs with
//   registered read (readback, upcoming slot), each with a write bypass.
// Reset:
//   rst is synchronous; both pipeline registers empty, registers return to
//   250/6/0, counters clear, all pins go low. Positions read as zero until
//   written (valid bit per channel, no clearing pass).
// Stall: a held rsp keeps its word; req.ready drops once the input register fills.
`default_nettype none

module multichannel_servo_pulse_generator #(
  parameter int NUM_CHANNELS = msp_pkg::NUM_CHANNELS_DEF,
  parameter int IDLE_WIDTH   = msp_pkg::IDLE_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  msp_req_if.sink                          req,
  msp_rsp_if.source                        rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [msp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [msp_pkg::PDATA_W-1:0] pwdata,
  output logic      [msp_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import msp_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [AW:0] NCH = (AW + 1)'(NUM_CHANNELS);

  cfg_t cfg;

  // input register
  logic               s1_valid;
  logic               s1_mode;
  logic [AW-1:0]      s1_ch;
  logic [COUNT_W-1:0] s1_pos;

  // result register
  logic                    rsp_valid;
  logic [NUM_CHANNELS-1:0] rsp_pins;
  status_t                 rsp_status;
  logic [COUNT_W-1:0]      rsp_pos;

  logic advance, go, s1_load;

  // engine side
  logic [NUM_CHANNELS-1:0] eng_pins;
  status_t                 eng_status;
  logic [COUNT_W-1:0]      eng_readback;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [COUNT_W-1:0]      wdata;
  logic [NUM_CHANNELS-1:0] pos_valid;

  // readback port with write bypass
  logic [AW-1:0]      rb_raddr;
  logic [COUNT_W-1:0] rb_rdata;
  logic               rb_hit, rb_vld;
  logic [COUNT_W-1:0] rb_byp;
  logic [COUNT_W-1:0] rb_pos;

  assign advance   = !rsp_valid || rsp.ready;
  assign go        = s1_valid && advance;
  assign req.ready = !s1_valid || advance;
  assign s1_load   = req.valid && req.ready;

  // re-read every cycle; a stalled word keeps its address
  assign rb_raddr = s1_load ? req.channel : s1_ch;
  assign rb_pos   = rb_hit ? rb_byp : (rb_vld ? rb_rdata : '0);

  msp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  msp_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_CHANNELS)
  ) u_rb_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  msp_engine #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDLE_WIDTH   (IDLE_WIDTH),
    .AW           (AW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .mode      (s1_mode),
    .ch        (s1_ch),
    .pos       (s1_pos),
    .cfg       (cfg),
    .rd_pos    (rb_pos),
    .pins      (eng_pins),
    .status    (eng_status),
    .readback  (eng_readback),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .pos_valid (pos_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      rb_hit    <= 1'b0;
      rb_vld    <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        rsp_valid <= s1_valid;
      end
      rb_hit <= we && (waddr == rb_raddr);
      rb_vld <= ({1'b0, rb_raddr} < NCH) && pos_valid[rb_raddr];
    end
    if (s1_load) begin
      s1_mode <= req.mode;
      s1_ch   <= req.channel;
      s1_pos  <= req.position;
    end
    if (go) begin
      rsp_pins   <= eng_pins;
      rsp_status <= eng_status;
      rsp_pos    <= eng_readback;
    end
    rb_byp <= wdata;
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.pins             = rsp_pins;
  assign rsp.status           = rsp_status;
  assign rsp.channel_position = rsp_pos;

  // only the active slot's pin can be high
  a_pins_onehot0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot0(rsp_pins))
    else $error("more than one servo pin high");

  // a rejected channel number reads back as zero
  a_bad_ch_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == ST_BAD_CHANNEL)) |-> (rsp_pos == '0))
    else $error("bad channel with nonzero readback");

  // a stalled result must not be overwritten
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ready) |=> (rsp_valid && $stable(rsp_pos) && $stable(rsp_pins)))
    else $error("result register changed under stall");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== rtl/core/msp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module msp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/msp_cfg.sv =====
// APB register file: slot length, prescaler and idle timeout.
`default_nettype none

module msp_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [msp_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [msp_pkg::PDATA_W-1:0]   pwdata,
  output logic      [msp_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output msp_pkg::cfg_t                      cfg
);
  import msp_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_ticks <= SLOT_TICKS_RST;
      cfg.prescale   <= PRESCALE_RST;
      cfg.idle_ticks <= IDLE_TICKS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SLOT_TICKS: cfg.slot_ticks <= pwdata[COUNT_W-1:0];
        REG_PRESCALE:   cfg.prescale   <= pwdata[PRESCALE_W-1:0];
        REG_IDLE_TICKS: cfg.idle_ticks <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SLOT_TICKS: prdata = PDATA_W'(cfg.slot_ticks);
      REG_PRESCALE:   prdata = PDATA_W'(cfg.prescale);
      REG_IDLE_TICKS: prdata = PDATA_W'(cfg.idle_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/msp_engine.sv =====
// Pulse engine: prescaler, slot sequencer, idle timeouts and position store.
`default_nettype none

module msp_engine #(
  parameter int NUM_CHANNELS = msp_pkg::NUM_CHANNELS_DEF,
  parameter int IDLE_WIDTH   = msp_pkg::IDLE_WIDTH_DEF,
  parameter int AW           = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic                          mode,
  input  wire logic [AW-1:0]                 ch,
  input  wire logic [msp_pkg::COUNT_W-1:0]   pos,
  input  wire msp_pkg::cfg_t                 cfg,
  input  wire logic [msp_pkg::COUNT_W-1:0]   rd_pos,
  output logic [NUM_CHANNELS-1:0]            pins,
  output msp_pkg::status_t                   status,
  output logic [msp_pkg::COUNT_W-1:0]        readback,
  output logic                               we,
  output logic [AW-1:0]                      waddr,
  output logic [msp_pkg::COUNT_W-1:0]        wdata,
  output logic [NUM_CHANNELS-1:0]            pos_valid
);
  import msp_pkg::*;

  localparam int CMP_W = (IDLE_WIDTH > TIMEOUT_W) ? IDLE_WIDTH : TIMEOUT_W;
  localparam logic [IDLE_WIDTH-1:0] IDLE_MAX = {IDLE_WIDTH{1'b1}};
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_CHANNELS - 1);
  localparam logic [AW:0]   NCH = (AW + 1)'(NUM_CHANNELS);

  // state
  logic [PRESCALE_W-1:0]   prescale_count, prescale_count_next;
  logic [COUNT_W-1:0]      tick_in_slot, tick_in_slot_next;
  logic [AW-1:0]           active_slot, active_slot_next;
  logic [COUNT_W-1:0]      latched_count, latched_count_next;
  logic [NUM_CHANNELS-1:0] pin_levels, pin_levels_next;
  logic [NUM_CHANNELS-1:0] channel_enabled, channel_enabled_next;
  logic [NUM_CHANNELS-1:0] pos_valid_next;
  logic [IDLE_WIDTH-1:0]   idle_counters [NUM_CHANNELS];
  logic [IDLE_WIDTH-1:0]   idle_counters_next [NUM_CHANNELS];
  logic [IDLE_WIDTH-1:0]   idle_inc [NUM_CHANNELS];

  // upcoming-slot read port with write bypass
  logic [AW-1:0]      slot_raddr;
  logic [COUNT_W-1:0] slot_rdata;
  logic               slot_hit, slot_vld;
  logic [COUNT_W-1:0] slot_byp;
  logic [COUNT_W-1:0] slot_pos;

  logic [PRESCALE_W:0] pc_inc;
  logic [COUNT_W-1:0]  t_inc;
  logic                ch_ok, cmd_ok, tick;

  assign slot_pos = slot_hit ? slot_byp : (slot_vld ? slot_rdata : '0);

  always_comb begin
    pc_inc = {1'b0, prescale_count} + (PRESCALE_W + 1)'(1);
    t_inc  = tick_in_slot + COUNT_W'(1);
    ch_ok  = {1'b0, ch} < NCH;
    cmd_ok = go && (mode == MODE_SET) && ch_ok && (pos < cfg.slot_ticks);
    tick   = go && (mode == MODE_TICK) && (pc_inc >= {1'b0, cfg.prescale});

    prescale_count_next  = prescale_count;
    tick_in_slot_next    = tick_in_slot;
    active_slot_next     = active_slot;
    latched_count_next   = latched_count;
    pin_levels_next      = pin_levels;
    channel_enabled_next = channel_enabled;
    pos_valid_next       = pos_valid;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      idle_counters_next[i] = idle_counters[i];
      idle_inc[i] = (idle_counters[i] == IDLE_MAX) ? idle_counters[i]
                                                   : idle_counters[i] + IDLE_WIDTH'(1);
    end

    if (go && (mode == MODE_TICK)) begin
      prescale_count_next = tick ? '0 : pc_inc[PRESCALE_W-1:0];
    end

    if (tick) begin
      // timeouts first: a channel that times out now is not latched below
      if (cfg.idle_ticks != '0) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (channel_enabled[i]) begin
            idle_counters_next[i] = idle_inc[i];
            if (CMP_W'(idle_inc[i]) >= CMP_W'(cfg.idle_ticks)) begin
              channel_enabled_next[i] = 1'b0;
            end
          end
        end
      end
      if (t_inc >= cfg.slot_ticks) begin
        tick_in_slot_next  = '0;
        active_slot_next   = (active_slot == LAST_SLOT) ? '0 : active_slot + AW'(1);
        latched_count_next = channel_enabled_next[active_slot_next] ? slot_pos : '0;
      end else begin
        tick_in_slot_next = t_inc;
      end
      pin_levels_next = '0;
      if (tick_in_slot_next < latched_count_next) begin
        pin_levels_next[active_slot_next] = 1'b1;
      end
    end

    if (cmd_ok) begin
      channel_enabled_next[ch] = 1'b1;
      idle_counters_next[ch]   = '0;
      pos_valid_next[ch]       = 1'b1;
    end

    slot_raddr = (active_slot_next == LAST_SLOT) ? '0 : active_slot_next + AW'(1);
  end

  assign we    = cmd_ok;
  assign waddr = ch;
  assign wdata = pos;

  // result of this word
  always_comb begin
    pins = pin_levels_next;
    if ((mode == MODE_SET) && !ch_ok) begin
      status = ST_BAD_CHANNEL;
    end else if ((mode == MODE_SET) && (pos >= cfg.slot_ticks)) begin
      status = ST_BAD_POSITION;
    end else begin
      status = ST_OK;
    end
    if (!ch_ok) begin
      readback = '0;
    end else if (cmd_ok) begin
      readback = pos;
    end else begin
      readback = rd_pos;
    end
  end

  msp_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_CHANNELS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count  <= '0;
      tick_in_slot    <= '0;
      active_slot     <= '0;
      latched_count   <= '0;
      pin_levels      <= '0;
      channel_enabled <= '0;
      pos_valid       <= '0;
      slot_hit        <= 1'b0;
      slot_vld        <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        idle_counters[i] <= '0;
      end
    end else begin
      prescale_count  <= prescale_count_next;
      tick_in_slot    <= tick_in_slot_next;
      active_slot     <= active_slot_next;
      latched_count   <= latched_count_next;
      pin_levels      <= pin_levels_next;
      channel_enabled <= channel_enabled_next;
      pos_valid       <= pos_valid_next;
      slot_hit        <= we && (waddr == slot_raddr);
      slot_vld        <= pos_valid[slot_raddr];
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        idle_counters[i] <= idle_counters_next[i];
      end
    end
    slot_byp <= wdata;
  end

endmodule

`default_nettype wire

// ===== tb/servo_checker.sv =====
// Checker for the servo pulse generator: predicts every result word and compares it, and checks APB register reads.
`timescale 1ns / 100ps

module servo_checker
  import msp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  msp_req_if                 req,
  msp_rsp_if                 rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending,
  output int                 n_results,
  output int                 n_rejected,
  output int                 n_high
);

  localparam int NCH = NUM_CHANNELS_DEF;

  typedef struct packed {
    logic [NCH-1:0]     pins;
    status_t            status;
    logic [COUNT_W-1:0] position;
  } servo_word_t;

  // register copies
  logic [COUNT_W-1:0]    cfg_slot;
  logic [PRESCALE_W-1:0] cfg_presc;
  logic [TIMEOUT_W-1:0]  cfg_idle;

  // pulse engine copy
  logic [COUNT_W-1:0]    stored_pos [NCH];
  logic [TIMEOUT_W-1:0]  idle_cnt   [NCH];
  logic [NCH-1:0]        enabled;
  logic [2:0]            slot;
  logic [COUNT_W-1:0]    tick;
  logic [COUNT_W-1:0]    latched;
  logic [PRESCALE_W-1:0] presc_cnt;
  logic [NCH-1:0]        pin_lv;

  servo_word_t awaited_words [$];

  // one word through the engine; returns the result it must produce
  function automatic servo_word_t servo_step(logic m, logic [2:0] c, logic [COUNT_W-1:0] p);
    servo_word_t r;
    int k;
    r.status = ST_OK;
    if (m == MODE_TICK) begin
      // prescale 0 behaves as 1
      if (int'(presc_cnt) + 1 >= int'(cfg_presc)) begin
        presc_cnt = '0;
        if (cfg_idle != '0) begin
          for (k = 0; k < NCH; k++) begin
            if (enabled[k]) begin
              if (idle_cnt[k] != '1) idle_cnt[k] = idle_cnt[k] + 1'b1;
              if (idle_cnt[k] >= cfg_idle) enabled[k] = 1'b0;
            end
          end
        end
        tick = tick + 1'b1;
        if (tick >= cfg_slot) begin
          tick    = '0;
          slot    = (int'(slot) == NCH - 1) ? 3'd0 : slot + 3'd1;
          latched = enabled[slot] ? stored_pos[slot] : '0;
        end
        pin_lv = (tick < latched) ? (NCH'(1) << slot) : '0;
      end else begin
        presc_cnt = presc_cnt + 1'b1;
      end
    end else if (int'(c) >= NCH) begin
      r.status = ST_BAD_CHANNEL;
    end else if (p >= cfg_slot) begin
      r.status = ST_BAD_POSITION;
    end else begin
      stored_pos[c] = p;
      enabled[c]    = 1'b1;
      idle_cnt[c]   = '0;
    end
    r.pins     = pin_lv;
    r.position = (int'(c) < NCH) ? stored_pos[c] : '0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    servo_word_t e;
    logic [PDATA_W-1:0] reg_val;
    if (rst) begin
      cfg_slot  = SLOT_TICKS_RST;
      cfg_presc = PRESCALE_RST;
      cfg_idle  = IDLE_TICKS_RST;
      for (int k = 0; k < NCH; k++) begin
        stored_pos[k] = '0;
        idle_cnt[k]   = '0;
      end
      enabled   = '0;
      slot      = '0;
      tick      = '0;
      latched   = '0;
      presc_cnt = '0;
      pin_lv    = '0;
      awaited_words.delete();
    end else begin
      // result first: a word accepted at this edge cannot answer itself
      if (rsp.valid && rsp.ready) begin
        if (awaited_words.size() == 0) begin
          errors++;
          $error("result word with none awaited: pins %02h status %0d position %0d",
                 rsp.pins, rsp.status, rsp.channel_position);
        end else begin
          e = awaited_words.pop_front();
          n_results++;
          if (e.status != ST_OK) n_rejected++;
          if (e.pins != '0) n_high++;
          if (rsp.pins !== e.pins) begin
            errors++;
            $error("pins: expected %02h, actual %02h", e.pins, rsp.pins);
          end
          if (rsp.status !== e.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", e.status, rsp.status);
          end
          if (rsp.channel_position !== e.position) begin
            errors++;
            $error("channel_position: expected %0d, actual %0d",
                   e.position, rsp.channel_position);
          end
        end
      end
      if (req.valid && req.ready)
        awaited_words.push_back(servo_step(req.mode, req.channel, req.position));
      if (psel && penable && pready) begin
        case (paddr[3:2])
          REG_SLOT_TICKS: reg_val = PDATA_W'(cfg_slot);
          REG_PRESCALE:   reg_val = PDATA_W'(cfg_presc);
          REG_IDLE_TICKS: reg_val = PDATA_W'(cfg_idle);
          default:        reg_val = '0;
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_SLOT_TICKS: cfg_slot  = pwdata[COUNT_W-1:0];
            REG_PRESCALE:   cfg_presc = pwdata[PRESCALE_W-1:0];
            REG_IDLE_TICKS: cfg_idle  = pwdata[TIMEOUT_W-1:0];
            default: ;
          endcase
        end else if (prdata !== reg_val) begin
          errors++;
          $error("prdata at %0h: expected %0h, actual %0h", paddr, reg_val, prdata);
        end
      end
    end
    pending = awaited_words.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the servo pulse generator testbench: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_top;
  import msp_pkg::*;

  localparam int HOLD_CYCLES = 60;  // long receiver hold-off, fills both pipeline stages
  localparam int TAIL_CYCLES = 8;   // idle time after the final drain for stragglers

  logic clk = 1'b0;
  logic rst;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  msp_req_if req ();
  msp_rsp_if rsp ();

  // flow control knobs, in percent of cycles
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  // hold-off requests: stimulus bumps hold_asked, the ready process serves it
  int hold_asked   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  int n_sent       = 0;
  int n_settings   = 1;  // reset values count as the first setting

  int errors;
  int pending;
  int n_results;
  int n_rejected;
  int n_high;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multichannel_servo_pulse_generator DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  servo_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .errors     (errors),
    .pending    (pending),
    .n_results  (n_results),
    .n_rejected (n_rejected),
    .n_high     (n_high)
  );

  // Result side. Ready moves at the falling edge only. A pending hold-off
  // wins over the random stall and is counted down here, cycle by cycle,
  // so the sender keeps pushing words into a blocked pipeline meanwhile.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // APB access: setup cycle, access cycle, then an idle spell with psel low
  // so that psel never gets two updates in one time step across calls.
  task automatic reg_access(bit wr, logic [1:0] idx, int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wr ? PDATA_W'(val) : '0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one word and wait for the handshake. Starts and ends at a falling
  // edge; valid stays high after acceptance so a following word goes out
  // back to back. Anything else that follows must drop valid first.
  task automatic send_word(logic m, logic [2:0] c, logic [COUNT_W-1:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.mode     <= m;
    req.channel  <= c;
    req.position <= p;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    n_sent++;
  endtask

  // Stop sending until every awaited result word has come back.
  // Always waits for a falling edge before it checks; valid is lowered exactly once.
  task automatic drain();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Random word: mostly clocks, some position commands. Positions are
  // mostly legal for the current slot length so channels get enabled and
  // pulses show up; the rest hit zero, the slot boundary, all-ones and noise.
  task automatic send_random(int slot_len, int cmd_pct);
    logic               m;
    logic [COUNT_W-1:0] p;
    m = ($urandom_range(99) < cmd_pct) ? MODE_SET : MODE_TICK;
    if (m == MODE_SET) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: p = (slot_len > 0) ? COUNT_W'($urandom_range(slot_len - 1, 0)) : '0;
        6:       p = '0;
        7:       p = COUNT_W'(slot_len);        // one past the last legal count
        8:       p = '1;
        default: p = COUNT_W'($urandom);
      endcase
    end else begin
      p = COUNT_W'($urandom);                   // ignored by a clock, still exercised
    end
    send_word(m, 3'($urandom_range(7)), p);
  endtask

  // One phase: drain, program all three registers, read them back, then
  // random traffic under one flow-control style.
  //   style 0: no idling, 1: sender idle, 2: receiver stalls, 3: both, lightly
  task automatic run_phase(int slot_len, int presc, int idle, int n, int cmd_pct, int style);
    int k;
    drain();
    reg_access(1'b1, REG_SLOT_TICKS, slot_len);
    reg_access(1'b1, REG_PRESCALE, presc);
    reg_access(1'b1, REG_IDLE_TICKS, idle);
    reg_access(1'b0, REG_SLOT_TICKS, 0);
    reg_access(1'b0, REG_PRESCALE, 0);
    reg_access(1'b0, REG_IDLE_TICKS, 0);
    n_settings++;
    case (style)
      0: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      1: begin
        tx_idle_pct  = 73;
        rx_stall_pct = 0;
      end
      2: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 73;
      end
      default: begin
        tx_idle_pct  = 12;
        rx_stall_pct = 12;
      end
    endcase
    for (k = 0; k < n; k++) begin
      // with a busy sender, a long hold-off backs the pipeline up to req
      if (k == 30 && tx_idle_pct == 0) hold_asked++;
      // every other phase, the sender stops mid-way until all results are home
      if (k == n / 2 && n_settings % 2 == 0) drain();
      send_random(slot_len, cmd_pct);
    end
  endtask

  initial begin
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.mode     = MODE_TICK;
    req.channel  = '0;
    req.position = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // registers must come up at their reset values
    reg_access(1'b0, REG_SLOT_TICKS, 0);
    reg_access(1'b0, REG_PRESCALE, 0);
    reg_access(1'b0, REG_IDLE_TICKS, 0);

    // Directed, at reset settings (250 ticks per slot, prescale 6):
    // zero count accepted, largest legal count, count equal to the slot
    // length and all-ones count rejected, then one full prescale period.
    send_word(MODE_SET, 3'd0, 12'd0);
    send_word(MODE_SET, 3'd7, 12'd249);
    send_word(MODE_SET, 3'd3, 12'd250);
    send_word(MODE_SET, 3'd5, 12'hFFF);
    for (int k = 0; k < 6; k++) send_word(MODE_TICK, 3'(k + 2), 12'd0);

    // Directed, shortest legal slot and fastest tick: a count of one gives a
    // one-tick pulse, two is already too long; walk most of a frame and read
    // back every channel along the way.
    drain();
    reg_access(1'b1, REG_SLOT_TICKS, 2);
    reg_access(1'b1, REG_PRESCALE, 1);
    reg_access(1'b1, REG_IDLE_TICKS, 0);
    n_settings++;
    send_word(MODE_SET, 3'd1, 12'd1);
    send_word(MODE_SET, 3'd6, 12'd2);
    send_word(MODE_SET, 3'd2, 12'd0);
    for (int k = 0; k < 12; k++) send_word(MODE_TICK, 3'(k), 12'hFFF);

    // Random phases. Order matters in two places: the long slot followed by
    // a short one shrinks the slot under a running tick count, and the
    // timeout is switched on after a phase where it was off.
    run_phase(6,    1,   0,        150, 20, 0);
    run_phase(10,   2,   25,       140, 20, 1);
    run_phase(3,    1,   4,        120, 25, 2);
    run_phase(4095, 1,   0,        80,  15, 3);
    run_phase(5,    1,   0,        120, 20, 0);
    run_phase(8,    1,   30,       120, 20, 1);
    run_phase(1,    1,   0,        60,  20, 2);  // slot below range: wraps every tick
    run_phase(0,    0,   0,        60,  20, 3);  // slot 0 rejects all counts, prescale 0 acts as 1
    run_phase(12,   255, 24'hFFFFFF, 80, 10, 0);
    run_phase(20,   3,   100,      140, 20, 1);
    run_phase(4,    1,   8,        150, 20, 2);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run covered %0d words over %0d register settings, with stalls and hold-offs.",
             n_sent, n_settings);
    $display("%0d results checked: %0d commands rejected, %0d with a pin driven high.",
             n_results, n_rejected, n_high);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("Timeout with %0d result words still awaited", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/msp_pkg.sv
rtl/core/msp_if.sv
rtl/core/msp_ram.sv
rtl/core/msp_cfg.sv
rtl/core/msp_engine.sv
rtl/core/multichannel_servo_pulse_generator.sv
tb/servo_checker.sv
tb/tb_top.sv
